[hw/rtl/cpoc_pkg.sv]
// ----------------------------------------------------------------------------
// cpoc_pkg
// shared types and codes of the closed path orientation classifier
// ----------------------------------------------------------------------------
package cpoc_pkg;

    typedef logic [2:0] class_t;
    typedef logic [2:0] axis_t;

    localparam int AREA_W = 64;

    localparam class_t CLASS_POS     = 3'd0;
    localparam class_t CLASS_NEG     = 3'd1;
    localparam class_t CLASS_ZERO    = 3'd2;
    localparam class_t CLASS_OOB     = 3'd3;
    localparam class_t CLASS_BADAXIS = 3'd4;

    localparam axis_t AXIS_POS_X = 3'd0;
    localparam axis_t AXIS_NEG_X = 3'd1;
    localparam axis_t AXIS_POS_Y = 3'd2;
    localparam axis_t AXIS_NEG_Y = 3'd3;
    localparam axis_t AXIS_POS_Z = 3'd4;
    localparam axis_t AXIS_NEG_Z = 3'd5;

    localparam axis_t AXIS_RESET = AXIS_POS_Z;

endpackage

[hw/rtl/cpoc_cross_mul.sv]
// ----------------------------------------------------------------------------
// cpoc_cross_mul
// registered partial products of the cross product a x b
// ----------------------------------------------------------------------------
module cpoc_cross_mul #(
    parameter int COORD_BITS = 24
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [COORD_BITS-1:0]    a [3],
    input  logic signed [COORD_BITS-1:0]    b [3],
    output logic signed [2*COORD_BITS-1:0]  prod_pos [3],
    output logic signed [2*COORD_BITS-1:0]  prod_neg [3]
);

    logic signed [2*COORD_BITS-1:0] prod_pos_reg [3];
    logic signed [2*COORD_BITS-1:0] prod_neg_reg [3];

    // component i is prod_pos[i] - prod_neg[i]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_pos_reg[0] <= a[1] * b[2];
            prod_neg_reg[0] <= a[2] * b[1];
            prod_pos_reg[1] <= a[2] * b[0];
            prod_neg_reg[1] <= a[0] * b[2];
            prod_pos_reg[2] <= a[0] * b[1];
            prod_neg_reg[2] <= a[1] * b[0];
        end
    end

    assign prod_pos = prod_pos_reg;
    assign prod_neg = prod_neg_reg;

endmodule

[hw/rtl/closed_path_orientation_classifier_core.sv]
// ----------------------------------------------------------------------------
// closed_path_orientation_classifier_core
// sums cross products of consecutive path points and classifies the sign
// of the sum projected onto a configured axis, or flags a grid exit or bad axis
// ----------------------------------------------------------------------------
// Points of one closed path arrive on the in channel (in_valid/in_ready),
// one point per transaction, with left_grid and last_point flags. The
// block accepts one point per cycle while in_ready is high. Each point passes
// an input register, a multiply stage (twelve independent products: step term
// and closing term), an accumulate stage and the result register, and the
// result of a path appears on the out channel once its last point has
// passed them all. Only a last point produces a result transaction.
// The user must write the axis code on the cfg channel (cfg_valid/cfg_ready,
// always ready) only while the block is idle; the block does not enforce it.
// Reset sets the axis code to +z, clears the pipeline, the running sum and
// the flags, and the next point starts a new path. When out_ready is low the
// result is held; the pipeline keeps taking points until a second result
// waits behind it and the two stages before that are full, then in_ready drops.
// ----------------------------------------------------------------------------
module closed_path_orientation_classifier_core #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic                         left_grid,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cpoc_pkg::class_t             orientation_class,
    output logic signed [63:0]           projected_area,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  cpoc_pkg::axis_t              field_direction
);

    import cpoc_pkg::*;

    localparam int PROD_W = 2 * COORD_BITS;

    logic signed [COORD_BITS-1:0] in_point [3];
    logic signed [COORD_BITS-1:0] first_point_reg [3];
    logic signed [COORD_BITS-1:0] previous_point_reg [3];
    logic                         at_path_start_reg;

    logic signed [COORD_BITS-1:0] s1_p_reg [3];
    logic signed [COORD_BITS-1:0] s1_prev_reg [3];
    logic signed [COORD_BITS-1:0] s1_first_reg [3];
    logic                         s1_valid_reg;
    logic                         s1_start_reg;
    logic                         s1_last_reg;
    logic                         s1_grid_reg;

    logic signed [PROD_W-1:0]     step_pos [3];
    logic signed [PROD_W-1:0]     step_neg [3];
    logic signed [PROD_W-1:0]     close_pos [3];
    logic signed [PROD_W-1:0]     close_neg [3];
    logic                         s2_valid_reg;
    logic                         s2_start_reg;
    logic                         s2_last_reg;
    logic                         s2_grid_reg;

    logic signed [AREA_W-1:0]     cross_sum_reg [3];
    logic                         grid_exit_seen_reg;
    logic signed [AREA_W-1:0]     cross_sum_next [3];
    logic                         grid_exit_seen_next;

    logic signed [AREA_W-1:0]     s3_sum_reg [3];
    logic                         s3_grid_reg;
    logic                         s3_valid_reg;

    axis_t                        field_direction_reg;
    logic                         out_valid_reg;
    class_t                       orientation_class_reg;
    logic signed [AREA_W-1:0]     projected_area_reg;
    class_t                       orientation_class_next;
    logic signed [AREA_W-1:0]     projected_area_next;
    logic signed [AREA_W-1:0]     axis_sum;

    logic                         adv_out;
    logic                         en3;
    logic                         en2;
    logic                         en1;
    logic                         in_accept;

    assign adv_out   = !out_valid_reg || out_ready;
    assign en3       = !s3_valid_reg || adv_out;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign in_ready  = en1;
    assign in_accept = in_valid && en1;
    assign cfg_ready = 1'b1;

    assign in_point[0] = point_x;
    assign in_point[1] = point_y;
    assign in_point[2] = point_z;

    // path state and input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_path_start_reg <= 1'b1;
            s1_valid_reg      <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                first_point_reg[i]    <= '0;
                previous_point_reg[i] <= '0;
            end
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (in_accept)
            begin
                at_path_start_reg <= last_point;
                for (int i = 0; i < 3; i++)
                begin
                    previous_point_reg[i] <= in_point[i];
                    if (at_path_start_reg)
                    begin
                        first_point_reg[i] <= in_point[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_start_reg <= at_path_start_reg;
            s1_last_reg  <= last_point;
            s1_grid_reg  <= left_grid;
            for (int i = 0; i < 3; i++)
            begin
                s1_p_reg[i]     <= in_point[i];
                s1_prev_reg[i]  <= previous_point_reg[i];
                s1_first_reg[i] <= at_path_start_reg ? in_point[i] : first_point_reg[i];
            end
        end
    end

    // multiply stage
    cpoc_cross_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_step_mul (
        .clk      (clk),
        .en       (en2),
        .a        (s1_prev_reg),
        .b        (s1_p_reg),
        .prod_pos (step_pos),
        .prod_neg (step_neg)
    );

    cpoc_cross_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_close_mul (
        .clk      (clk),
        .en       (en2),
        .a        (s1_p_reg),
        .b        (s1_first_reg),
        .prod_pos (close_pos),
        .prod_neg (close_neg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_start_reg <= s1_start_reg;
            s2_last_reg  <= s1_last_reg;
            s2_grid_reg  <= s1_grid_reg;
        end
    end

    // accumulate stage
    always_comb
    begin
        logic signed [AREA_W-1:0] step_term;
        logic signed [AREA_W-1:0] close_term;
        for (int i = 0; i < 3; i++)
        begin
            step_term  = AREA_W'(step_pos[i]) - AREA_W'(step_neg[i]);
            close_term = AREA_W'(close_pos[i]) - AREA_W'(close_neg[i]);
            if (s2_start_reg)
            begin
                step_term = '0;
            end
            if (!s2_last_reg)
            begin
                close_term = '0;
            end
            cross_sum_next[i] = (s2_start_reg ? '0 : cross_sum_reg[i]) + step_term
                                + close_term;
        end
        grid_exit_seen_next = (!s2_start_reg && grid_exit_seen_reg) || s2_grid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg       <= 1'b0;
            grid_exit_seen_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cross_sum_reg[i] <= '0;
            end
        end
        else if (en3)
        begin
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg)
            begin
                grid_exit_seen_reg <= grid_exit_seen_next;
                cross_sum_reg      <= cross_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_sum_reg  <= cross_sum_next;
            s3_grid_reg <= grid_exit_seen_next;
        end
    end

    // projection and classification
    always_comb
    begin
        case (field_direction_reg)
            AXIS_POS_X: axis_sum = s3_sum_reg[0];
            AXIS_NEG_X: axis_sum = -s3_sum_reg[0];
            AXIS_POS_Y: axis_sum = s3_sum_reg[1];
            AXIS_NEG_Y: axis_sum = -s3_sum_reg[1];
            AXIS_POS_Z: axis_sum = s3_sum_reg[2];
            AXIS_NEG_Z: axis_sum = -s3_sum_reg[2];
            default:    axis_sum = '0;
        endcase

        projected_area_next = '0;
        if (field_direction_reg > AXIS_NEG_Z)
        begin
            orientation_class_next = CLASS_BADAXIS;
        end
        else if (s3_grid_reg)
        begin
            orientation_class_next = CLASS_OOB;
        end
        else
        begin
            projected_area_next = axis_sum;
            if (axis_sum == '0)
            begin
                orientation_class_next = CLASS_ZERO;
            end
            else if (axis_sum[AREA_W-1])
            begin
                orientation_class_next = CLASS_NEG;
            end
            else
            begin
                orientation_class_next = CLASS_POS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            field_direction_reg <= AXIS_RESET;
        end
        else
        begin
            if (adv_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                field_direction_reg <= field_direction;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            orientation_class_reg <= orientation_class_next;
            projected_area_reg    <= projected_area_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign orientation_class = orientation_class_reg;
    assign projected_area    = projected_area_reg;

endmodule

[hw/rtl/cpoc_checker.sv]
// ----------------------------------------------------------------------------
// cpoc_checker
// port level checks of the result channel
// ----------------------------------------------------------------------------
module cpoc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  cpoc_pkg::class_t   orientation_class,
    input  logic signed [63:0] projected_area
);

    import cpoc_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(orientation_class)
            && $stable(projected_area))
        else $error("result changed while stalled");

    // error classes and the zero class carry no area
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (orientation_class == CLASS_OOB
            || orientation_class == CLASS_BADAXIS || orientation_class == CLASS_ZERO)
        |-> projected_area == '0)
        else $error("nonzero area with error or zero class");

    // class agrees with sign of area
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && orientation_class == CLASS_NEG |-> projected_area[63])
        else $error("negative class with nonnegative area");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && orientation_class == CLASS_POS
        |-> !projected_area[63] && projected_area != '0)
        else $error("positive class with nonpositive area");

endmodule

bind closed_path_orientation_classifier_core cpoc_checker u_cpoc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .orientation_class (orientation_class),
    .projected_area    (projected_area)
);

[dv/tb_closed_path_orientation_classifier_core.sv]
// ----------------------------------------------------------------------------
// tb_closed_path_orientation_classifier_core
// self-checking bench for the closed path orientation classifier: directed
// and random closed paths are streamed point by point under changing axis
// codes and idle patterns, and every result transaction is compared with a
// transaction-level model of the cross-product sum and its axis projection
// ----------------------------------------------------------------------------
module tb_closed_path_orientation_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cpoc_pkg::*;

    localparam int COORD_W = 24;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_POINTS = 244;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = 24'h7fffff;
    localparam coord_t COORD_MIN = 24'h800000;
    localparam coord_t ONE = 24'h001000;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   lg;
        logic   lp;
    } point_t;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec3_t;

    typedef struct {
        class_t cls;
        longint area;
    } path_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    coord_t             point_x = '0;
    coord_t             point_y = '0;
    coord_t             point_z = '0;
    logic               left_grid = 1'b0;
    logic               last_point = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    class_t             orientation_class;
    logic signed [63:0] projected_area;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    axis_t              field_direction = AXIS_RESET;

    point_t       pending_points[$];
    path_result_t expected_areas[$];

    vec3_t first_pt;
    vec3_t prev_pt;
    vec3_t cross_acc;
    bit    new_path = 1'b1;
    bit    grid_exit = 1'b0;
    axis_t axis_sel = AXIS_RESET;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    closed_path_orientation_classifier_core #(
        .COORD_BITS(COORD_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .point_x(point_x),
        .point_y(point_y),
        .point_z(point_z),
        .left_grid(left_grid),
        .last_point(last_point),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .orientation_class(orientation_class),
        .projected_area(projected_area),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .field_direction(field_direction)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t c;
        c.x = a.y * b.z - a.z * b.y;
        c.y = a.z * b.x - a.x * b.z;
        c.z = a.x * b.y - a.y * b.x;
        return c;
    endfunction

    function automatic vec3_t vadd(vec3_t a, vec3_t b);
        vec3_t c;
        c.x = a.x + b.x;
        c.y = a.y + b.y;
        c.z = a.z + b.z;
        return c;
    endfunction

    // running vector area of the open path, closed and projected on the last point
    function automatic void accumulate_point(point_t pt);
        vec3_t        p;
        path_result_t res;
        p.x = longint'(pt.x);
        p.y = longint'(pt.y);
        p.z = longint'(pt.z);
        if (new_path)
        begin
            first_pt = p;
            cross_acc = '{default: 0};
            grid_exit = 1'b0;
            new_path = 1'b0;
        end
        else
        begin
            cross_acc = vadd(cross_acc, cross3(prev_pt, p));
        end
        prev_pt = p;
        if (pt.lg)
            grid_exit = 1'b1;
        if (!pt.lp)
            return;
        cross_acc = vadd(cross_acc, cross3(p, first_pt));
        res.area = 0;
        if (axis_sel > AXIS_NEG_Z)
        begin
            res.cls = CLASS_BADAXIS;
        end
        else if (grid_exit)
        begin
            res.cls = CLASS_OOB;
        end
        else
        begin
            case (axis_sel)
                AXIS_POS_X: res.area = cross_acc.x;
                AXIS_NEG_X: res.area = -cross_acc.x;
                AXIS_POS_Y: res.area = cross_acc.y;
                AXIS_NEG_Y: res.area = -cross_acc.y;
                AXIS_POS_Z: res.area = cross_acc.z;
                default:    res.area = -cross_acc.z;
            endcase
            if (res.area == 0)
                res.cls = CLASS_ZERO;
            else if (res.area < 0)
                res.cls = CLASS_NEG;
            else
                res.cls = CLASS_POS;
        end
        expected_areas.push_back(res);
        cross_acc = '{default: 0};
        grid_exit = 1'b0;
        new_path = 1'b1;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3, 4: return coord_t'($urandom_range(8191) - 4096);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic void queue_point(coord_t x, coord_t y, coord_t z, bit lg, bit lp);
        point_t pt;
        pt.x = x;
        pt.y = y;
        pt.z = z;
        pt.lg = lg;
        pt.lp = lp;
        pending_points.push_back(pt);
    endfunction

    task automatic wait_idle();
        while (pending_points.size() != 0 || in_valid || expected_areas.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // point driver
    always @(posedge clk)
    begin : drive_points
        point_t cur;
        point_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cur = '{point_x, point_y, point_z, left_grid, last_point};
                accumulate_point(cur);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_points.pop_front();
                    in_valid <= 1'b1;
                    point_x <= nxt.x;
                    point_y <= nxt.y;
                    point_z <= nxt.z;
                    left_grid <= nxt.lg;
                    last_point <= nxt.lp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        path_result_t exp_res;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_areas.size() == 0)
                begin
                    $error("result transaction with none expected: class %0d area %0d",
                           orientation_class, projected_area);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = expected_areas.pop_front();
                    if (orientation_class !== exp_res.cls)
                    begin
                        $error("orientation_class expected %0d actual %0d",
                               exp_res.cls, orientation_class);
                        mismatch_count++;
                    end
                    if (projected_area !== exp_res.area)
                    begin
                        $error("projected_area expected %0d actual %0d",
                               exp_res.area, projected_area);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        int     queued;
        int     path_len;
        int     shape;
        coord_t plane_z;
        coord_t ax;
        coord_t ay;
        point_t pt;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // single point paths
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b1);
        // counterclockwise and clockwise triangles about +z
        queue_point('0, '0, '0, 1'b0, 1'b0);
        queue_point(ONE, '0, '0, 1'b0, 1'b0);
        queue_point('0, ONE, '0, 1'b0, 1'b1);
        queue_point('0, '0, '0, 1'b0, 1'b0);
        queue_point('0, ONE, '0, 1'b0, 1'b0);
        queue_point(ONE, '0, '0, 1'b0, 1'b1);
        // grid left mid path, on a lone point, and on the last point
        queue_point(ONE, '0, '0, 1'b0, 1'b0);
        queue_point('0, ONE, '0, 1'b1, 1'b0);
        queue_point('0, '0, ONE, 1'b0, 1'b1);
        queue_point(24'sd1, 24'sd2, 24'sd3, 1'b1, 1'b1);
        queue_point(-ONE, '0, 24'sd5, 1'b0, 1'b0);
        queue_point('0, -ONE, 24'sd5, 1'b0, 1'b0);
        queue_point(ONE, ONE, 24'sd5, 1'b1, 1'b1);
        // corner values
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        queue_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
        queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0, 1'b1);
        queue_point(COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        queue_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            field_direction <= axis_t'(ph);
            do
                @(posedge clk);
            while (!cfg_ready);
            axis_sel = axis_t'(ph);
            cfg_valid <= 1'b0;

            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct = 26;
                    recv_stall_pct = 26;
                end
            endcase

            queued = 0;
            while (queued < PHASE_POINTS)
            begin
                path_len = ($urandom_range(9) == 0) ? $urandom_range(40, 9)
                                                    : $urandom_range(6, 1);
                shape = $urandom_range(5);
                plane_z = rand_coord();
                ax = rand_coord();
                ay = rand_coord();
                for (int i = 0; i < path_len; i++)
                begin
                    pt.x = rand_coord();
                    pt.y = rand_coord();
                    pt.z = rand_coord();
                    // flat in z: x and y components cancel around the loop
                    if (shape == 3)
                        pt.z = plane_z;
                    // one repeated point: every component cancels
                    if (shape == 4)
                    begin
                        pt.x = ax;
                        pt.y = ay;
                        pt.z = plane_z;
                    end
                    pt.lg = ($urandom_range(39) == 0);
                    pt.lp = (i == path_len - 1);
                    pending_points.push_back(pt);
                end
                queued += path_len;
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/cpoc_pkg.sv
hw/rtl/cpoc_cross_mul.sv
hw/rtl/closed_path_orientation_classifier_core.sv
hw/rtl/cpoc_checker.sv
dv/tb_closed_path_orientation_classifier_core.sv
